// ===== design/assert_macros.svh =====
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/dsdec_pkg.sv =====
package dsdec_pkg;

  typedef struct packed {
    logic [27:0] program_word;
    logic [15:0] control_word;
    logic [7:0]  slot_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  io_control;
    logic [2:0]  iram_bank;
    logic [5:0]  cell_index;
    logic [2:0]  transfer;
    logic [1:0]  eram_command;
    logic [2:0]  slot_kind;
    logic [4:0]  alu_op;
    logic [1:0]  multiply_kind;
    logic [4:0]  multiply_sources;
    logic [4:0]  factor_control;
    logic [3:0]  post_transform;
    logic [11:0] branch;
  } out_item_t;

  // iram banks
  localparam logic [2:0] BANK_MIXER   = 3'd0;
  localparam logic [2:0] BANK_PROC    = 3'd1;
  localparam logic [2:0] BANK_DIRECT1 = 3'd2;
  localparam logic [2:0] BANK_DIRECT2 = 3'd3;
  localparam logic [2:0] BANK_IRAM3   = 3'd4;

  // iram transfers
  localparam logic [2:0] XFER_NONE       = 3'd0;
  localparam logic [2:0] XFER_RD_STATE   = 3'd1;
  localparam logic [2:0] XFER_RD_PARAM   = 3'd2;
  localparam logic [2:0] XFER_WR_ERAM_LT = 3'd3;
  localparam logic [2:0] XFER_WR_ACC     = 3'd4;

  // eram commands
  localparam logic [1:0] ECMD_NONE     = 2'd0;
  localparam logic [1:0] ECMD_READ     = 2'd1;
  localparam logic [1:0] ECMD_WR_LATCH = 2'd2;
  localparam logic [1:0] ECMD_WR_ACC   = 2'd3;

  // slot kinds
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_PRIMARY  = 3'd1;
  localparam logic [2:0] KIND_BRANCH   = 3'd2;
  localparam logic [2:0] KIND_IDX_READ = 3'd3;
  localparam logic [2:0] KIND_PARALLEL = 3'd4;

  // op field codes with function zero
  localparam logic [5:0] OP_BRANCH   = 6'h10;
  localparam logic [5:0] OP_IDX_READ = 6'h20;
  localparam logic [5:0] OP_PARALLEL = 6'h30;

  // alu numbers used by name
  localparam logic [4:0] ALU_HOLD        = 5'd1;
  localparam logic [4:0] ALU_ACC_MUL_SHR = 5'd16;
  localparam logic [4:0] ALU_MUL_SHR     = 5'd17;
  localparam logic [4:0] ALU_LOGIC_BASE  = 5'd17;
  localparam logic [4:0] ALU_MINMAX_BASE = 5'd21;
  localparam logic [4:0] ALU_IMM_BASE    = 5'd25;

  localparam logic [1:0] MKIND_NONE   = 2'd0;
  localparam logic [1:0] MKIND_COEF   = 2'd1;
  localparam logic [1:0] MKIND_FACTOR = 2'd2;

  // multiplicand codes for the serial nodes
  localparam logic [2:0] MCAND_SER_A = 3'd4;
  localparam logic [2:0] MCAND_SER_B = 3'd5;

  localparam logic [6:0] BOUNDARY_RESET = 7'd64;

  // branch condition from the 4-bit condition field
  function automatic logic [2:0] branch_cond(input logic [3:0] c);
    logic [2:0] r;
    unique case (c)
      4'd0:    r = 3'd2;
      4'd1:    r = 3'd3;
      4'd2:    r = 3'd0;
      4'd3:    r = 3'd1;
      4'd4:    r = 3'd0;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd4;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd7;
      4'd12:   r = 3'd0;
      4'd13:   r = 3'd1;
      4'd14:   r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // codes 6 and 7 mean no transform
  function automatic logic [2:0] post_xform(input logic [2:0] t);
    return (t == 3'd6 || t == 3'd7) ? 3'd0 : t;
  endfunction

endpackage

// ===== design/dsp_slot_instruction_decoder_unit.sv =====
// slot instruction decoder for the audio dsp sequencer
//
// input channel: in_valid_i / in_stall_o carry one item per slot, the program
//   word, control word and slot address packed in in_item_i
// output channel: out_valid_o / out_stall_i carry the decoded fields of the
//   slot in out_item_o, one result item for every input item, in order
// config: cfg_wr_en_i loads cfg_wr_data_i into the parameter read boundary,
//   taking effect for items decoded afterwards
// path: an accepted item passes through the input register and then the
//   result register before it shows on out_valid_o and can be taken
// throughput: one item per clock while the output is not stalled
// reset: both stages are emptied and the boundary returns to 64
// stall: a stalled result holds in the output register while the input
//   register still takes one more item; in_stall_o rises only when both
//   registers are full and the output is stalled
module dsp_slot_instruction_decoder_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dsdec_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dsdec_pkg::out_item_t out_item_o,
  input  logic                 cfg_wr_en_i,
  input  logic [6:0]           cfg_wr_data_i
);
  import dsdec_pkg::*;

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t dec_result;
  logic [6:0] boundary_q, boundary_d;
  logic      out_load;   // result register may take a new item
  logic      s1_load;    // input register may take a new item
  logic      in_accept;
  logic      res_none;   // valid result of a slot with no kind
  logic      res_idle;   // alu holds and multiplier is off

  // result register frees up when empty or when its item is taken
  assign out_load  = !out_valid_q || !out_stall_i;
  assign s1_load   = !s1_valid_q || out_load;
  assign in_accept = in_valid_i && s1_load;
  assign in_stall_o = !s1_load;

  always_comb begin
    s1_valid_d  = s1_load ? in_valid_i : s1_valid_q;
    out_valid_d = out_load ? s1_valid_q : out_valid_q;
    boundary_d  = cfg_wr_en_i ? cfg_wr_data_i : boundary_q;
  end

  dsdec_decode u_decode (
    .item_i     (s1_item_q),
    .boundary_i (boundary_q),
    .result_o   (dec_result)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      boundary_q  <= BOUNDARY_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      boundary_q  <= boundary_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    if (out_load && s1_valid_q) begin
      out_item_q <= dec_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign res_none = out_valid_o && (out_item_o.slot_kind == KIND_NONE);
  assign res_idle = (out_item_o.alu_op == ALU_HOLD) &&
                    (out_item_o.multiply_kind == MKIND_NONE);

`include "assert_macros.svh"

  // an accepted item always lands in the input register
  `ASSERT_NEXT(a_accept_lands, in_accept, s1_valid_q)
  // backpressure only when both registers hold items
  `ASSERT_IMPLIES(a_stall_full, in_stall_o, s1_valid_q && out_valid_q)
  // a held input-register item keeps its contents
  `ASSERT_NEXT(a_s1_hold, s1_valid_q && !out_load, s1_valid_q && $stable(s1_item_q))
  // slots with no kind leave alu and multiplier idle
  `ASSERT_IMPLIES(a_none_idle, res_none, res_idle)

endmodule

// ===== design/dsdec_decode.sv =====
module dsdec_decode (
  input  dsdec_pkg::in_item_t  item_i,
  input  logic [6:0]           boundary_i,
  output dsdec_pkg::out_item_t result_o
);
  import dsdec_pkg::*;

  logic [27:0] word;
  logic [15:0] ctl;
  logic [7:0]  addr;
  logic [5:0]  op;
  logic [3:0]  fn;
  logic [1:0]  mode;
  logic [5:0]  bcond;
  logic [8:0]  target;
  logic [2:0]  mcand;
  logic [1:0]  fback;

  always_comb begin
    word  = item_i.program_word;
    ctl   = item_i.control_word;
    addr  = word[13:6];
    op    = word[5:0];
    fn    = word[3:0];
    mode  = word[5:4];
    bcond = ctl[13:8];
    mcand = 3'd0;
    fback = 2'd0;

    result_o = '0;
    result_o.io_control = word[27:25];
    result_o.alu_op     = ALU_HOLD;

    // bank and cell from the memory address
    if (!addr[7]) begin
      result_o.iram_bank  = addr[6] ? BANK_PROC : BANK_MIXER;
      result_o.cell_index = addr[5:0];
    end else if (!addr[6]) begin
      result_o.iram_bank  = addr[5] ? BANK_DIRECT2 : BANK_DIRECT1;
      result_o.cell_index = {1'b1, addr[4:0]};
    end else begin
      result_o.iram_bank  = BANK_IRAM3;
      result_o.cell_index = addr[5:0];
    end

    priority if (word[24]) begin
      result_o.eram_command = word[23] ? ECMD_WR_ACC : ECMD_WR_LATCH;
    end else if (word[23]) begin
      result_o.eram_command = ECMD_READ;
    end else begin
      result_o.eram_command = ECMD_NONE;
    end

    unique case (word[15:14])
      2'd1: begin
        result_o.transfer = (result_o.iram_bank == BANK_IRAM3 &&
                             {1'b0, result_o.cell_index} >= boundary_i)
                            ? XFER_RD_PARAM : XFER_RD_STATE;
      end
      2'd2:    result_o.transfer = XFER_WR_ERAM_LT;
      2'd3:    result_o.transfer = XFER_WR_ACC;
      default: result_o.transfer = XFER_NONE;
    endcase

    // relative target fits in 9 bits
    target = bcond[1] ? (9'({1'b0, item_i.slot_address}) + 9'd1 + 9'({1'b0, ctl[7:0]}))
                      : {1'b0, ctl[7:0]};

    if (fn != 4'd0) begin
      result_o.slot_kind = KIND_PRIMARY;
      unique case (fn)
        4'd12: result_o.alu_op = (mode == 2'd2) ? ALU_ACC_MUL_SHR :
                                 (mode == 2'd3) ? ALU_MUL_SHR : ALU_HOLD;
        4'd13: result_o.alu_op = (mode == 2'd0) ? ALU_HOLD
                                                : ALU_LOGIC_BASE + 5'(mode);
        4'd14: result_o.alu_op = ALU_MINMAX_BASE + 5'(mode);
        4'd15: result_o.alu_op = ALU_IMM_BASE + 5'(mode);
        4'd1:  result_o.alu_op = ALU_HOLD;
        default: result_o.alu_op = {1'b0, fn};
      endcase
      if (fn <= 4'd12) begin
        result_o.multiply_kind = MKIND_COEF;
        fback = mode;
        if (fn == 4'd12) begin
          mcand = (mode == 2'd0) ? MCAND_SER_A : (mode == 2'd1) ? MCAND_SER_B : 3'd0;
        end else begin
          mcand = {1'b0, mode};
        end
      end
    end else if (op == OP_BRANCH) begin
      result_o.slot_kind = KIND_BRANCH;
      result_o.branch    = {branch_cond(bcond[5:2]), target};
    end else if (op == OP_IDX_READ) begin
      result_o.slot_kind = KIND_IDX_READ;
    end else if (op == OP_PARALLEL) begin
      result_o.slot_kind      = KIND_PARALLEL;
      result_o.alu_op         = {1'b0, ctl[3:0]};
      result_o.post_transform = {ctl[10], post_xform(ctl[13:11])};
      if (ctl[9]) begin
        result_o.multiply_kind  = MKIND_FACTOR;
        mcand                   = {1'b0, ctl[5:4]};
        fback                   = ctl[5:4];
        result_o.factor_control = {ctl[15:14], ctl[8], ctl[7:6]};
      end
    end

    result_o.multiply_sources = {mcand, fback};
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dsdec_pkg::*;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 140;
  localparam int SETTLE_CYCLES = 4;

  // function field codes
  localparam logic [3:0] FN_NONE      = 4'd0;
  localparam logic [3:0] FN_HOLD      = 4'd1;
  localparam logic [3:0] FN_MUL_SHIFT = 4'd12;
  localparam logic [3:0] FN_LOGIC     = 4'd13;
  localparam logic [3:0] FN_MINMAX    = 4'd14;
  localparam logic [3:0] FN_IMM       = 4'd15;

  // store field codes
  localparam logic [1:0] STORE_NONE   = 2'd0;
  localparam logic [1:0] STORE_READ   = 2'd1;
  localparam logic [1:0] STORE_ERAM   = 2'd2;
  localparam logic [1:0] STORE_ACC    = 2'd3;

  // branch conditions
  localparam logic [2:0] COND_NEVER  = 3'd0;
  localparam logic [2:0] COND_ALWAYS = 3'd1;
  localparam logic [2:0] COND_EQ     = 3'd2;
  localparam logic [2:0] COND_NE     = 3'd3;
  localparam logic [2:0] COND_GE     = 3'd4;
  localparam logic [2:0] COND_LT     = 3'd5;
  localparam logic [2:0] COND_GT     = 3'd6;
  localparam logic [2:0] COND_LE     = 3'd7;

  // post transforms
  localparam logic [2:0] XF_NONE = 3'd0;
  localparam logic [2:0] XF_LAST = 3'd5;

  logic        clk_i;
  logic        rst_ni;
  logic        slot_valid;
  logic        slot_stall;
  in_item_t    slot_item;
  logic        decode_valid;
  logic        decode_stall;
  out_item_t   decode_item;
  logic        bound_wr_en;
  logic [6:0]  bound_wr_data;

  in_item_t    pending_slots[$];
  out_item_t   expected_decodes[$];
  out_item_t   want_decode;
  logic [6:0]  bound_shadow;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          mismatches;
  int          cycle_count;

  dsp_slot_instruction_decoder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (slot_valid),
    .in_stall_o    (slot_stall),
    .in_item_i     (slot_item),
    .out_valid_o   (decode_valid),
    .out_stall_i   (decode_stall),
    .out_item_o    (decode_item),
    .cfg_wr_en_i   (bound_wr_en),
    .cfg_wr_data_i (bound_wr_data)
  );

  // 4-bit condition field to branch condition
  function automatic logic [2:0] branch_condition(input logic [3:0] c);
    case (c)
      4'd0:           return COND_EQ;
      4'd1:           return COND_NE;
      4'd6, 4'd8:     return COND_GE;
      4'd7, 4'd9:     return COND_LT;
      4'd10:          return COND_GT;
      4'd11:          return COND_LE;
      4'd3, 4'd5,
      4'd13, 4'd14:   return COND_ALWAYS;
      default:        return COND_NEVER;
    endcase
  endfunction

  // full decode of one slot against the current read boundary
  function automatic out_item_t decode_slot(input in_item_t s, input logic [6:0] bound);
    out_item_t   d;
    logic [8:0]  eram;
    logic [1:0]  store;
    logic [7:0]  addr;
    logic [5:0]  op;
    logic [1:0]  mode;
    logic [3:0]  fn;
    logic [15:0] ctl;
    logic [5:0]  cc;
    logic [8:0]  tgt;
    logic [2:0]  mcand;
    logic [1:0]  fback;
    logic [2:0]  xf;
    eram  = s.program_word[24:16];
    store = s.program_word[15:14];
    addr  = s.program_word[13:6];
    op    = s.program_word[5:0];
    mode  = op[5:4];
    fn    = op[3:0];
    ctl   = s.control_word;
    mcand = '0;
    fback = '0;
    d = '0;
    d.io_control = s.program_word[27:25];
    d.alu_op     = ALU_HOLD;

    // bank and cell from the memory address
    if (!addr[7]) begin
      d.iram_bank  = addr[6] ? BANK_PROC : BANK_MIXER;
      d.cell_index = addr[5:0];
    end else if (!addr[6]) begin
      d.iram_bank  = addr[5] ? BANK_DIRECT2 : BANK_DIRECT1;
      d.cell_index = {1'b1, addr[4:0]};
    end else begin
      d.iram_bank  = BANK_IRAM3;
      d.cell_index = addr[5:0];
    end

    if (eram[8])      d.eram_command = eram[7] ? ECMD_WR_ACC : ECMD_WR_LATCH;
    else if (eram[7]) d.eram_command = ECMD_READ;
    else              d.eram_command = ECMD_NONE;

    case (store)
      STORE_READ: begin
        d.transfer = (d.iram_bank == BANK_IRAM3 && {1'b0, d.cell_index} >= bound) ?
                     XFER_RD_PARAM : XFER_RD_STATE;
      end
      STORE_ERAM: d.transfer = XFER_WR_ERAM_LT;
      STORE_ACC:  d.transfer = XFER_WR_ACC;
      default:    d.transfer = XFER_NONE;
    endcase

    if (fn != FN_NONE) begin
      d.slot_kind = KIND_PRIMARY;
      case (fn)
        FN_HOLD:      d.alu_op = ALU_HOLD;
        FN_MUL_SHIFT: d.alu_op = (mode == 2'd2) ? ALU_ACC_MUL_SHR :
                                 (mode == 2'd3) ? ALU_MUL_SHR : ALU_HOLD;
        FN_LOGIC:     d.alu_op = (mode == 2'd0) ? ALU_HOLD : ALU_LOGIC_BASE + 5'(mode);
        FN_MINMAX:    d.alu_op = ALU_MINMAX_BASE + 5'(mode);
        FN_IMM:       d.alu_op = ALU_IMM_BASE + 5'(mode);
        default:      d.alu_op = 5'(fn);
      endcase
      // coefficient multiply for everything up to the multiply-shift group
      if (fn <= FN_MUL_SHIFT) begin
        d.multiply_kind = MKIND_COEF;
        fback = mode;
        if (fn == FN_MUL_SHIFT)
          mcand = (mode == 2'd0) ? MCAND_SER_A : (mode == 2'd1) ? MCAND_SER_B : 3'd0;
        else
          mcand = {1'b0, mode};
      end
    end else if (op == OP_BRANCH) begin
      cc  = ctl[13:8];
      // relative targets may run past the end of the program
      tgt = cc[1] ? 9'(s.slot_address) + 9'd1 + 9'(ctl[7:0]) : 9'(ctl[7:0]);
      d.slot_kind = KIND_BRANCH;
      d.branch    = {branch_condition(cc[5:2]), tgt};
    end else if (op == OP_IDX_READ) begin
      d.slot_kind = KIND_IDX_READ;
    end else if (op == OP_PARALLEL) begin
      d.slot_kind = KIND_PARALLEL;
      d.alu_op    = 5'(ctl[3:0]);
      xf = ctl[13:11];
      d.post_transform = {ctl[10], (xf > XF_LAST) ? XF_NONE : xf};
      if (ctl[9]) begin
        d.multiply_kind  = MKIND_FACTOR;
        mcand            = {1'b0, ctl[5:4]};
        fback            = ctl[5:4];
        d.factor_control = {ctl[15:14], ctl[8], ctl[7:6]};
      end
    end
    d.multiply_sources = {mcand, fback};
    return d;
  endfunction

  function automatic in_item_t make_slot(input logic [2:0] io, input logic [8:0] eram,
                                         input logic [1:0] store, input logic [7:0] addr,
                                         input logic [5:0] op, input logic [15:0] ctl,
                                         input logic [7:0] pc);
    in_item_t s;
    s.program_word = {io, eram, store, addr, op};
    s.control_word = ctl;
    s.slot_address = pc;
    return s;
  endfunction

  // queue one slot for the sender
  function automatic void add_slot(input in_item_t s);
    pending_slots = {pending_slots, s};
  endfunction

  // mostly well-formed slots of each kind, the rest raw noise
  function automatic in_item_t random_slot();
    int         pick;
    logic [5:0] op;
    logic [7:0] addr;
    logic [7:0] pc;
    pick = $urandom_range(99);
    if (pick < 35)      op = {2'($urandom), 4'($urandom_range(15, 1))};
    else if (pick < 55) op = OP_BRANCH;
    else if (pick < 65) op = OP_IDX_READ;
    else if (pick < 85) op = OP_PARALLEL;
    else                op = 6'($urandom);
    // lean toward iram3 so the read boundary gets exercised
    addr = ($urandom_range(99) < 40) ? {2'b11, 6'($urandom)} : 8'($urandom);
    pc   = ($urandom_range(99) < 10) ? 8'hff : 8'($urandom);
    return make_slot(3'($urandom), 9'($urandom), 2'($urandom), addr, op, 16'($urandom), pc);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender: hold the item until it is taken, then maybe idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      slot_valid <= 1'b0;
    end else begin
      if (slot_valid && !slot_stall)
        expected_decodes = {expected_decodes, decode_slot(slot_item, bound_shadow)};
      if (!slot_valid || !slot_stall) begin
        if (pending_slots.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          slot_valid <= 1'b1;
          slot_item  <= pending_slots.pop_front();
        end else begin
          slot_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall, check every result taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      decode_stall <= 1'b0;
    end else begin
      decode_stall <= ($urandom_range(99) < receiver_stall_pct);
      if (decode_valid && !decode_stall) begin
        if (expected_decodes.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected decode result %p", decode_item);
          mismatches++;
        end else begin
          want_decode = expected_decodes.pop_front();
          if (decode_item !== want_decode) begin
            if (mismatches < REPORT_LIMIT)
              $display("decode mismatch\n  expected %p\n  actual   %p", want_decode, decode_item);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dsp_slot_instruction_decoder_unit regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_slots.size() != 0 || slot_valid || expected_decodes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_boundary(input logic [6:0] value);
    @(posedge clk_i);
    bound_wr_en   <= 1'b1;
    bound_wr_data <= value;
    @(posedge clk_i);
    bound_wr_en   <= 1'b0;
    bound_shadow   = value;
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [6:0] bound,
                           input bit hold_mid);
    write_boundary(bound);
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // sender holds off until the block is empty
      if (hold_mid && i == PHASE_ITEMS / 2)
        wait_drained();
      add_slot(random_slot());
    end
    wait_drained();
  endtask

  initial begin
    rst_ni             = 1'b0;
    slot_valid         = 1'b0;
    slot_item          = '0;
    decode_stall       = 1'b0;
    bound_wr_en        = 1'b0;
    bound_wr_data      = '0;
    bound_shadow       = BOUNDARY_RESET;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatches         = 0;
    cycle_count        = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed slots at the reset boundary
    add_slot(make_slot('0, '0, STORE_NONE, 8'h00, 6'h00, 16'h0000, 8'h00));
    add_slot(make_slot('1, '1, STORE_ACC, 8'hff, 6'h3f, 16'hffff, 8'hff));
    for (int f = 1; f < 16; f++)
      add_slot(make_slot(3'(f), 9'(f * 37), 2'(f), 8'(f * 17),
                         {2'(f), 4'(f)}, 16'(f * 4099), 8'(f)));
    // relative branch from the last slot runs to the top target
    add_slot(make_slot('0, 9'h080, STORE_READ, 8'hc5, OP_BRANCH, 16'h02ff, 8'hff));
    // absolute branch with the never condition
    add_slot(make_slot(3'd5, 9'h100, STORE_ERAM, 8'h40, OP_BRANCH, 16'h3d5a, 8'h10));
    add_slot(make_slot(3'd2, 9'h180, STORE_READ, 8'hbf, OP_IDX_READ, 16'h1234, 8'h80));
    // parallel with factor multiply and an unused transform code
    add_slot(make_slot('0, '0, STORE_READ, 8'hff, OP_PARALLEL, 16'hffff, 8'h00));
    add_slot(make_slot('0, '0, STORE_NONE, 8'h80, OP_PARALLEL, 16'h3405, 8'h00));
    add_slot(make_slot('0, '0, STORE_READ, 8'hc0, OP_PARALLEL, 16'h2a7e, 8'h00));
    add_slot(make_slot('0, '0, STORE_READ, 8'hbf, 6'h00, 16'hffff, 8'hff));
    wait_drained();

    run_phase(0, 0, 7'd0, 1'b0);
    run_phase(64, 0, BOUNDARY_RESET, 1'b0);
    run_phase(0, 64, 7'($urandom_range(63, 1)), 1'b0);
    run_phase(8, 8, 7'd63, 1'b0);
    run_phase(0, 0, 7'($urandom_range(63, 1)), 1'b1);

    if (mismatches == 0)
      $display("dsp_slot_instruction_decoder_unit regression: pass");
    else
      $display("dsp_slot_instruction_decoder_unit regression: fail");
    $finish;
  end

endmodule
